### rtl/remote_command_window_parser_core_macros.svh
// Assertion macros used by the checker file of the command window parser.
`ifndef REMOTE_COMMAND_WINDOW_PARSER_CORE_MACROS_SVH
`define REMOTE_COMMAND_WINDOW_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RCWP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RCWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rcwp_pkg.sv
// Shared types, characters and event codes of the command window parser.
`default_nettype none

package rcwp_pkg;

    // Window geometry: WINDOW_LEN plus one stored bytes.
    localparam int WINDOW_LEN = 16;
    localparam int WIN_DEPTH  = WINDOW_LEN + 1;
    localparam int STEP_W     = $clog2(WIN_DEPTH);

    // At most this many events per scan, followed by the done event.
    localparam int EVENT_CAP = 16;
    localparam int EVT_W     = $clog2(EVENT_CAP + 1);

    typedef logic [7:0]        t_byte;
    typedef logic signed [7:0] t_speed;
    typedef logic [2:0]        t_kind;
    typedef logic [3:0][7:0]   t_taps;

    // Window control: advance by one place, and choose what enters the tail.
    typedef struct packed {
        logic  shift_en;
        logic  load_sel;
        logic  clear_head;
        t_byte din;
    } t_win_ctrl;

    // Event codes.
    localparam t_kind KIND_STOP  = 3'd4;
    localparam t_kind KIND_SPEED = 3'd5;
    localparam t_kind KIND_DONE  = 3'd6;

    // Characters the scan looks for.
    localparam t_byte CH_F     = 8'h46;
    localparam t_byte CH_X     = 8'h58;
    localparam t_byte CH_Y     = 8'h59;
    localparam t_byte CH_S     = 8'h53;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_1     = 8'h31;
    localparam t_byte CH_4     = 8'h34;
    localparam t_byte CH_9     = 8'h39;

    localparam int SPEED_MAX = 99;

endpackage

`default_nettype wire

### rtl/rcwp_window.sv
// Byte window held as a shift line that appends a byte or rotates in place, optionally clearing the head.
`default_nettype none

module rcwp_window
    import rcwp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_win_ctrl i_ctrl,
    output t_taps          o_taps
);

    t_byte r_win [WIN_DEPTH];
    t_byte n_tail;

    // The tail takes a new byte on append, a zero when the head is cleared, or the old head on rotation.
    always_comb begin
        if (i_ctrl.load_sel) begin
            n_tail = i_ctrl.din;
        end else if (i_ctrl.clear_head) begin
            n_tail = '0;
        end else begin
            n_tail = r_win[0];
        end
    end

    // Every step moves all bytes one place toward the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_ctrl.shift_en) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[WIN_DEPTH - 1] <= n_tail;
        end
    end

    // The scan looks at the head and the three bytes behind it.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_taps[k] = r_win[k];
        end
    end

endmodule

`default_nettype wire

### rtl/rcwp_value_unit.sv
// Speed value parser applied to the three bytes after a speed marker.
`default_nettype none

module rcwp_value_unit
    import rcwp_pkg::*;
(
    input  wire t_byte i_b1,
    input  wire t_byte i_b2,
    input  wire t_byte i_b3,
    output t_speed     o_value
);

    logic signed [12:0] d1;
    logic signed [12:0] d2;
    logic signed [12:0] d3;
    logic signed [12:0] pos_val;
    logic signed [12:0] neg_val;
    logic signed [12:0] raw_val;
    logic               b2_digit;

    // Digit offsets; a byte that is no digit gives an offset outside 0 to 9.
    assign d1 = $signed({5'b0, i_b1}) - 13'sd48;
    assign d2 = $signed({5'b0, i_b2}) - 13'sd48;
    assign d3 = $signed({5'b0, i_b3}) - 13'sd48;

    // Times ten as two shifts and an add.
    assign pos_val = (d1 <<< 3) + (d1 <<< 1) + d2;
    assign neg_val = -((d2 <<< 3) + (d2 <<< 1) + d3);

    assign b2_digit = (i_b2 >= CH_0) && (i_b2 <= CH_9);

    // A minus sign wins over the digit check; then clamp out-of-range to zero.
    always_comb begin
        if (i_b1 == CH_MINUS) begin
            raw_val = neg_val;
        end else if (b2_digit) begin
            raw_val = pos_val;
        end else begin
            raw_val = '0;
        end
        if ((raw_val > 13'(SPEED_MAX)) || (raw_val < -13'(SPEED_MAX))) begin
            o_value = '0;
        end else begin
            o_value = raw_val[7:0];
        end
    end

endmodule

`default_nettype wire

### rtl/remote_command_window_parser_core.sv
// Command window parser top level: scan sequencer, speed state and result register.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------------
//  input   | i_in_valid / o_in_ready | i_cmd, i_data_byte
//  output  | o_out_valid/ i_out_ready| o_event_kind, o_forward_value, o_turn_value,
//          |                         | o_last_flag
//
// A scan rotates the window through the head tap twice, one byte per cycle while the
// output side does not stall, then issues the done event.
// Each rotation step waits while the result register holds an untaken event.
// Reset clears the window, both speeds and the sequencer.
`default_nettype none

module remote_command_window_parser_core
    import rcwp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire logic  i_cmd,
    input  wire t_byte i_data_byte,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_kind      o_event_kind,
    output t_speed     o_forward_value,
    output t_speed     o_turn_value,
    output logic       o_last_flag
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PASS1 = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [EVT_W-1:0]  r_evt, n_evt;
    t_speed            r_fwd, n_fwd;
    t_speed            r_turn, n_turn;

    logic              r_o_valid;
    t_kind             r_o_kind;
    t_speed            r_o_fwd;
    t_speed            r_o_turn;
    logic              r_o_last;

    t_win_ctrl         win_ctrl;
    t_taps             taps;
    t_speed            value;
    t_byte             btn_off;
    logic              out_free;
    logic              last_step;
    logic              emit;
    logic              emit_ok;
    t_kind             emit_kind;

    rcwp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (win_ctrl),
        .o_taps  (taps)
    );

    rcwp_value_unit u_value (
        .i_b1    (taps[1]),
        .i_b2    (taps[2]),
        .i_b3    (taps[3]),
        .o_value (value)
    );

    assign out_free  = !r_o_valid || i_out_ready;
    assign last_step = (r_step == STEP_W'(WIN_DEPTH - 1));
    assign btn_off   = taps[1] - CH_1;

    // Sequencer: each scan step inspects the head byte and rotates the window.
    always_comb begin
        n_state            = r_state;
        n_step             = r_step;
        n_fwd              = r_fwd;
        n_turn             = r_turn;
        win_ctrl.shift_en   = 1'b0;
        win_ctrl.load_sel   = 1'b0;
        win_ctrl.clear_head = 1'b0;
        win_ctrl.din        = i_data_byte;
        emit               = 1'b0;
        emit_kind          = KIND_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_cmd) begin
                        win_ctrl.shift_en = 1'b1;
                        win_ctrl.load_sel = 1'b1;
                    end else begin
                        n_state = S_PASS1;
                        n_step  = '0;
                    end
                end
            end
            S_PASS1: begin
                if (out_free) begin
                    win_ctrl.shift_en = 1'b1;
                    if ((r_step < STEP_W'(WINDOW_LEN)) && (taps[0] == CH_F)) begin
                        win_ctrl.clear_head = 1'b1;
                        if ((taps[1] >= CH_1) && (taps[1] <= CH_4)) begin
                            emit      = 1'b1;
                            emit_kind = btn_off[2:0];
                        end else if (taps[1] == CH_S) begin
                            emit      = 1'b1;
                            emit_kind = KIND_STOP;
                        end
                    end
                    if (last_step) begin
                        n_state = S_PASS2;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_PASS2: begin
                if (out_free) begin
                    win_ctrl.shift_en = 1'b1;
                    if (r_step < STEP_W'(WINDOW_LEN - 2)) begin
                        if (taps[0] == CH_X) begin
                            win_ctrl.clear_head = 1'b1;
                            n_fwd              = value;
                            emit               = (value != r_fwd);
                            emit_kind          = KIND_SPEED;
                        end else if (taps[0] == CH_Y) begin
                            win_ctrl.clear_head = 1'b1;
                            n_turn             = value;
                            emit               = (value != r_turn);
                            emit_kind          = KIND_SPEED;
                        end
                    end
                    if (last_step) begin
                        n_state = S_DONE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Events past the cap still update the speeds but are not sent.
    assign emit_ok = emit && ((emit_kind == KIND_DONE) || (r_evt < EVT_W'(EVENT_CAP)));

    always_comb begin
        n_evt = r_evt;
        if ((r_state == S_IDLE) && i_in_valid && i_cmd) begin
            n_evt = '0;
        end else if (emit_ok && (emit_kind != KIND_DONE)) begin
            n_evt = r_evt + 1'b1;
        end
    end

    // Control and speed state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_evt   <= '0;
            r_fwd   <= '0;
            r_turn  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_evt   <= n_evt;
            r_fwd   <= n_fwd;
            r_turn  <= n_turn;
        end
    end

    // Result register: holds one event until the output transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit_ok) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ok) begin
            r_o_kind <= emit_kind;
            r_o_fwd  <= n_fwd;
            r_o_turn <= n_turn;
            r_o_last <= (emit_kind == KIND_DONE);
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_event_kind    = r_o_kind;
    assign o_forward_value = r_o_fwd;
    assign o_turn_value    = r_o_turn;
    assign o_last_flag     = r_o_last;

endmodule

`default_nettype wire

### rtl/rcwp_checker.sv
// Port-level checker for the command window parser and its bind statement.
`default_nettype none

`include "remote_command_window_parser_core_macros.svh"

module rcwp_checker
    import rcwp_pkg::*;
(
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   i_in_valid,
    input wire logic   o_in_ready,
    input wire logic   i_cmd,
    input wire logic   o_out_valid,
    input wire logic   i_out_ready,
    input wire t_kind  o_event_kind,
    input wire t_speed o_forward_value,
    input wire t_speed o_turn_value,
    input wire logic   o_last_flag
);

    // A stalled result keeps its payload.
    `RCWP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_event_kind) && $stable(o_forward_value) && $stable(o_turn_value) && $stable(o_last_flag), "stalled result changed")

    // The last flag marks the done event and nothing else.
    `RCWP_ASSERT_NOW(a_last_done, o_out_valid, (o_last_flag == 1'b1) == (o_event_kind == KIND_DONE), "last flag and done kind disagree")

    // A scan transaction closes the input side for at least the next cycle.
    `RCWP_ASSERT_NEXT(a_scan_busy, i_in_valid && o_in_ready && i_cmd, !o_in_ready, "input ready right after a scan transaction")

    // Reported speeds stay within the clamp range.
    `RCWP_ASSERT_NOW(a_speed_range, o_out_valid, (o_forward_value >= -8'sd99) && (o_forward_value <= 8'sd99) && (o_turn_value >= -8'sd99) && (o_turn_value <= 8'sd99), "speed outside range")

endmodule

bind remote_command_window_parser_core rcwp_checker u_rcwp_checker (.*);

`default_nettype wire
